// ===== sv/eps_pkg.sv =====
// Shared types and constants of the evacuation page selector.
// No dependencies; every module of the block imports it.
package eps_pkg;

  localparam int unsigned MaxPages = 64;
  localparam int unsigned IdW      = 16;
  localparam int unsigned BytesW   = 21;
  localparam int unsigned BudgetW  = 32;
  localparam int unsigned CountW   = 7;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [BytesW-1:0]  ThresholdReset = BytesW'(262144);
  localparam logic [BudgetW-1:0] BudgetReset    = BudgetW'(4194304);

  localparam logic RegThreshold = 1'b0;
  localparam logic RegBudget    = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BytesW-1:0] bytes;
  } page_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/eps_cell.sv =====
// One slot of the sorted insertion chain: holds a page, takes a new page or
// its left neighbor's page on insert, takes its right neighbor's on drain.
// Depends on eps_pkg.
module eps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eps_pkg::cell_ctrl_t ctrl_i,
  input  eps_pkg::page_t     new_i,
  input  eps_pkg::page_t     left_page_i,
  input  logic               left_valid_i,
  input  logic               left_gt_i,
  input  eps_pkg::page_t     right_page_i,
  input  logic               right_valid_i,
  output eps_pkg::page_t     page_o,
  output logic               valid_o,
  output logic               gt_o
);
  import eps_pkg::*;

  page_t page_q, page_d;
  logic  valid_q, valid_d;

  assign gt_o    = !valid_q || (page_q.bytes > new_i.bytes);
  assign page_o  = page_q;
  assign valid_o = valid_q;

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      page_d  = right_page_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        page_d  = left_page_i;
        valid_d = left_valid_i;
      end else begin
        page_d  = new_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// ===== sv/eps_walker.sv =====
// Greedy budget walk over the head of the drained chain; holds one chosen
// page back so the final result can carry the last flag. Depends on eps_pkg.
module eps_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          walk_i,
  input  eps_pkg::page_t                head_i,
  input  logic                          head_valid_i,
  input  logic [eps_pkg::BudgetW-1:0]   budget_i,
  input  logic                          overflow_i,
  output logic                          result_valid_o,
  output logic [eps_pkg::IdW-1:0]       chosen_page_id_o,
  output logic [eps_pkg::BytesW-1:0]    chosen_live_bytes_o,
  output logic                          has_selection_o,
  output logic [eps_pkg::CountW-1:0]    selected_count_o,
  output logic [eps_pkg::BudgetW-1:0]   selected_total_o,
  output logic                          table_overflow_o,
  output logic                          last_result_o
);
  import eps_pkg::*;

  logic [BudgetW-1:0] total_q, total_d;
  logic [CountW-1:0]  count_q, count_d;
  page_t              pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic [BudgetW:0]   sum;
  logic               fits;

  logic               res_vld_q, res_vld_d;
  page_t              res_page_q, res_page_d;
  logic               res_has_q, res_has_d;
  logic [CountW-1:0]  res_count_q, res_count_d;
  logic [BudgetW-1:0] res_total_q, res_total_d;
  logic               res_ovf_q, res_ovf_d;
  logic               res_last_q, res_last_d;

  assign sum  = {1'b0, total_q} + (BudgetW+1)'(head_i.bytes);
  assign fits = sum <= {1'b0, budget_i};

  always_comb begin
    total_d     = total_q;
    count_d     = count_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    res_vld_d   = 1'b0;
    res_page_d  = res_page_q;
    res_has_d   = res_has_q;
    res_count_d = res_count_q;
    res_total_d = res_total_q;
    res_ovf_d   = res_ovf_q;
    res_last_d  = res_last_q;
    if (walk_i) begin
      if (head_valid_i) begin
        if (fits) begin
          total_d    = sum[BudgetW-1:0];
          count_d    = count_q + CountW'(1);
          pend_d     = head_i;
          pend_vld_d = 1'b1;
          if (pend_vld_q) begin
            res_vld_d   = 1'b1;
            res_page_d  = pend_q;
            res_has_d   = 1'b1;
            res_count_d = count_q;
            res_total_d = total_q;
            res_ovf_d   = overflow_i;
            res_last_d  = 1'b0;
          end
        end
      end else begin
        res_vld_d   = 1'b1;
        res_ovf_d   = overflow_i;
        res_last_d  = 1'b1;
        if (pend_vld_q) begin
          res_page_d  = pend_q;
          res_has_d   = 1'b1;
          res_count_d = count_q;
          res_total_d = total_q;
        end else begin
          res_page_d  = '0;
          res_has_d   = 1'b0;
          res_count_d = '0;
          res_total_d = '0;
        end
        total_d    = '0;
        count_d    = '0;
        pend_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      total_q    <= total_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    res_page_q  <= res_page_d;
    res_has_q   <= res_has_d;
    res_count_q <= res_count_d;
    res_total_q <= res_total_d;
    res_ovf_q   <= res_ovf_d;
    res_last_q  <= res_last_d;
  end

  assign result_valid_o      = res_vld_q;
  assign chosen_page_id_o    = res_page_q.id;
  assign chosen_live_bytes_o = res_page_q.bytes;
  assign has_selection_o     = res_has_q;
  assign selected_count_o    = res_count_q;
  assign selected_total_o    = res_total_q;
  assign table_overflow_o    = res_ovf_q;
  assign last_result_o       = res_last_q;

endmodule

// ===== sv/evacuation_page_selector_top.sv =====
// Load: one page per cycle while busy_o is low; the chain of MAX_PAGES cells
// inserts each eligible page into sorted position in the cycle it is taken,
// unless the chain is full. After the last page, busy_o stays high while
// the chain drains into the walker, at most one result per cycle; the final
// result shows in the cycle busy_o falls. The receiver cannot stall.
// Reset empties the chain, clears overflow and walk state, and restores registers.
module evacuation_page_selector_top #(
  parameter int unsigned MAX_PAGES = eps_pkg::MaxPages
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eps_pkg::AddrW-1:0]     paddr,
  input  logic [eps_pkg::DataW-1:0]     pwdata,
  output logic [eps_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [eps_pkg::IdW-1:0]       page_id_i,
  input  logic [eps_pkg::BytesW-1:0]    page_live_bytes_i,
  input  logic                          never_move_i,
  input  logic                          last_page_i,
  output logic                          result_valid_o,
  output logic [eps_pkg::IdW-1:0]       chosen_page_id_o,
  output logic [eps_pkg::BytesW-1:0]    chosen_live_bytes_o,
  output logic                          has_selection_o,
  output logic [eps_pkg::CountW-1:0]    selected_count_o,
  output logic [eps_pkg::BudgetW-1:0]   selected_total_o,
  output logic                          table_overflow_o,
  output logic                          last_result_o
);
  import eps_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic               state_q, state_d;
  logic               overflow_q, overflow_d;
  logic [BytesW-1:0]  thresh_q;
  logic [BudgetW-1:0] budget_q;

  logic       accept, eligible, full, walking, cfg_wr;
  page_t      in_page;
  cell_ctrl_t ctrl;

  page_t page_w  [MAX_PAGES];
  logic  valid_w [MAX_PAGES];
  logic  gt_w    [MAX_PAGES];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegBudget) ? DataW'(budget_q) : DataW'(thresh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
      budget_q <= BudgetReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegThreshold) begin
        thresh_q <= pwdata[BytesW-1:0];
      end else begin
        budget_q <= pwdata[BudgetW-1:0];
      end
    end
  end

  assign busy_o   = (state_q == StWalk);
  assign walking  = (state_q == StWalk);
  assign accept   = start_i && !busy_o;
  assign eligible = !never_move_i && (page_live_bytes_i <= thresh_q);
  assign full     = valid_w[MAX_PAGES-1];
  assign in_page  = '{id: page_id_i, bytes: page_live_bytes_i};

  assign ctrl.ins   = accept && eligible && !full;
  assign ctrl.shift = walking && valid_w[0];

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    if (accept && eligible && full) begin
      overflow_d = 1'b1;
    end
    case (state_q)
      StIdle: begin
        if (accept && last_page_i) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (!valid_w[0]) begin
          state_d    = StIdle;
          overflow_d = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  for (genvar k = 0; k < MAX_PAGES; k++) begin : g_cell
    page_t lp, rp;
    logic  lv, lg, rv;
    if (k == 0) begin : g_first
      assign lp = in_page;
      assign lv = 1'b0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lp = page_w[k-1];
      assign lv = valid_w[k-1];
      assign lg = gt_w[k-1];
    end
    if (k == MAX_PAGES - 1) begin : g_last
      assign rp = page_w[k];
      assign rv = 1'b0;
    end else begin : g_inner
      assign rp = page_w[k+1];
      assign rv = valid_w[k+1];
    end
    eps_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_i         (in_page),
      .left_page_i   (lp),
      .left_valid_i  (lv),
      .left_gt_i     (lg),
      .right_page_i  (rp),
      .right_valid_i (rv),
      .page_o        (page_w[k]),
      .valid_o       (valid_w[k]),
      .gt_o          (gt_w[k])
    );
  end

  eps_walker u_walker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .walk_i              (walking),
    .head_i              (page_w[0]),
    .head_valid_i        (valid_w[0]),
    .budget_i            (budget_q),
    .overflow_i          (overflow_q),
    .result_valid_o      (result_valid_o),
    .chosen_page_id_o    (chosen_page_id_o),
    .chosen_live_bytes_o (chosen_live_bytes_o),
    .has_selection_o     (has_selection_o),
    .selected_count_o    (selected_count_o),
    .selected_total_o    (selected_total_o),
    .table_overflow_o    (table_overflow_o),
    .last_result_o       (last_result_o)
  );

endmodule

// ===== sv/eps_checker.sv =====
// Port-level checks of the evacuation page selector, bound to the top level.
// Depends on eps_pkg and evacuation_page_selector_top.
module eps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [eps_pkg::BytesW-1:0]    chosen_live_bytes_o,
  input logic                          has_selection_o,
  input logic [eps_pkg::CountW-1:0]    selected_count_o,
  input logic [eps_pkg::BudgetW-1:0]   selected_total_o,
  input logic                          last_result_o
);
  import eps_pkg::*;

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !has_selection_o |-> last_result_o)
    else $error("empty result without last flag");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !has_selection_o |->
      selected_count_o == '0 && selected_total_o == '0)
    else $error("empty result with nonzero count or total");

  a_chosen_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && has_selection_o |->
      selected_count_o != '0 && BudgetW'(chosen_live_bytes_o) <= selected_total_o)
    else $error("chosen result inconsistent with running count or total");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |=> !result_valid_o)
    else $error("result transfer right after final result");

  a_done_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && last_result_o)
    else $error("walk ended without final result");

endmodule

bind evacuation_page_selector_top eps_checker u_eps_checker (.*);
